// ----- rtl/core/bta_pkg.sv -----
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants for the boundary tag heap allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int HEAP_WORDS_DEFAULT = 4096;

  localparam logic       REQ_ALLOC     = 1'b0;
  localparam logic       REQ_FREE      = 1'b1;
  localparam logic [1:0] ST_ALLOCATED  = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_FREED      = 2'd2;

endpackage

// ----- rtl/core/bta_if.sv -----
// ----------------------------------------------------------------------------
// bta_req_if / bta_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface bta_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [13:0] num_bytes;
  logic [13:0] free_addr;
  modport source (output valid, req_type, num_bytes, free_addr, input ready);
  modport sink   (input valid, req_type, num_bytes, free_addr, output ready);
endinterface

interface bta_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [13:0] alloc_addr;
  modport source (output valid, status, alloc_addr, input ready);
  modport sink   (input valid, status, alloc_addr, output ready);
endinterface

// ----- rtl/core/bta_tag_ram.sv -----
// ----------------------------------------------------------------------------
// bta_tag_ram
// Tag memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bta_tag_ram #(
  parameter int AW = 12,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  // Registered read; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/boundary_tag_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// First-fit heap allocator with boundary tags kept in one synchronous memory.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// req     | in        | req_type, num_bytes, free_addr
// rsp     | out       | status, alloc_addr
//
// An allocate reads one tag per block walked and, on a fit, splits the block
// with four tag writes; a free reads up to four tags (lower, upper, below,
// above), then makes two writes, and stops sooner when a check ends it early.
// All of it goes through the single memory port. After reset a clearing pass
// writes the initial tags to every word; no request is taken meanwhile. A
// response waits in its output register while rsp.ready is low; the next request is then held.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator import bta_pkg::*; #(
  parameter int HEAP_WORDS = HEAP_WORDS_DEFAULT
) (
  input logic clk,
  input logic rst,
  bta_req_if.sink   req,
  bta_rsp_if.source rsp
);
  localparam int AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
  localparam int VW = (AW + 3 > 15) ? AW + 3 : 15;   // signed working width
  localparam int DW = AW + 2;   // stored tag width
  localparam logic signed [VW-1:0] HW  = VW'(HEAP_WORDS);
  localparam logic signed [VW-1:0] TOP = VW'(HEAP_WORDS - 2);
  localparam logic signed [VW-1:0] K2  = VW'(2);
  localparam logic signed [VW-1:0] K4  = VW'(4);

  localparam logic [4:0] S_CLR = 5'd0,  S_IDLE = 5'd1,  S_AR = 5'd2,  S_AW = 5'd3,
                         S_AW1 = 5'd4,  S_AW2 = 5'd5,  S_AW3 = 5'd6,  S_AW4 = 5'd7,
                         S_F0 = 5'd8,   S_F0W = 5'd9,  S_F1 = 5'd10,  S_F1W = 5'd11,
                         S_F2 = 5'd12,  S_F2W = 5'd13, S_F3 = 5'd14,  S_F3W = 5'd15,
                         S_FW1 = 5'd16, S_FW2 = 5'd17, S_OUT = 5'd18;

  logic [4:0] state;
  logic [AW:0] clr_cnt;
  logic signed [VW-1:0] idx, nw, v, n, lt, ut, bv, av;
  logic [AW:0] steps;
  logic below, above;
  logic signed [VW-1:0] w1a, w1v, w2a, w2v;
  logic [1:0]  status_r;
  logic [13:0] addr_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic signed [VW-1:0] wa_s, wv_s, ra_s, rd_s;
  logic signed [VW-1:0] fa_w;

  bta_tag_ram #(.AW(AW), .DW(DW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign rd_s  = VW'($signed(rdata));
  assign waddr = wa_s[AW-1:0];
  assign raddr = ra_s[AW-1:0];
  assign fa_w  = VW'(req.free_addr[13:2]);

  // Saturate a tag value to the legal range.
  function automatic logic signed [VW-1:0] sat(input logic signed [VW+1:0] x);
    if (x > (VW+2)'(HW)) return HW;
    if (x < -(VW+2)'(HW)) return -HW;
    return VW'(x);
  endfunction

  function automatic logic inh(input logic signed [VW-1:0] a);
    return (a >= 0) && (a < HW);
  endfunction

  // Memory port control.
  always_comb begin
    we = 1'b0; wa_s = '0; wv_s = '0; ra_s = idx;
    unique case (state)
      S_CLR: begin
        we = 1'b1; wa_s = VW'(clr_cnt);
        wv_s = (clr_cnt == 0 || clr_cnt == (AW+1)'(HEAP_WORDS - 2)) ? HW - K4 : '0;
      end
      S_AW1, S_FW1: begin we = inh(w1a); wa_s = w1a; wv_s = w1v; end
      S_AW2, S_FW2: begin we = inh(w2a); wa_s = w2a; wv_s = w2v; end
      S_AW3: begin we = inh(lt); wa_s = lt; wv_s = n; end
      S_AW4: begin we = inh(ut); wa_s = ut; wv_s = n; end
      default: ra_s = idx;
    endcase
    wdata = wv_s[DW-1:0];
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.status = status_r;
  assign rsp.alloc_addr = addr_r;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(HEAP_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          addr_r <= '0;
          if (req.req_type == REQ_ALLOC) begin
            nw <= VW'((15'(req.num_bytes) + 15'd3) >> 2);
            idx <= TOP; steps <= '0;
            status_r <= ST_NO_SPACE;
            state <= (req.num_bytes == 0) ? S_OUT : S_AR;
          end else begin
            status_r <= ST_FREED;
            lt <= fa_w - K2;
            idx <= fa_w - K2;
            below <= 1'b0; above <= 1'b0;
            // A lower tag outside the heap names no allocated block.
            state <= (req.free_addr < 14'd8 || fa_w - K2 >= HW) ? S_OUT : S_F0;
          end
        end
        S_AR: state <= S_AW;
        S_AW: begin
          if (rd_s >= nw + K4) begin
            if (idx - rd_s - K2 < 0) state <= S_OUT;
            else begin
              w1a <= idx;             w1v <= sat((VW+2)'(-nw));
              w2a <= idx - nw - K2;   w2v <= sat((VW+2)'(-nw));
              lt  <= idx - nw - K4;   n <= sat((VW+2)'(rd_s - nw - K4));
              ut  <= idx - rd_s - K2;
              status_r <= ST_ALLOCATED;
              addr_r <= 14'((idx - nw) << 2);
              state <= S_AW1;
            end
          end else begin
            idx <= idx - (rd_s < 0 ? -rd_s : rd_s) - K4;
            steps <= steps + 1'b1;
            if (idx - (rd_s < 0 ? -rd_s : rd_s) - K4 < K2 ||
                steps == (AW+1)'(HEAP_WORDS - 1)) state <= S_OUT;
            else state <= S_AR;
          end
        end
        S_AW1: state <= S_AW2;
        S_AW2: state <= S_AW3;
        S_AW3: state <= S_AW4;
        S_AW4: state <= S_OUT;
        // Free: read lower tag, upper tag, below, above.
        S_F0: state <= S_F0W;
        S_F0W: begin
          v <= rd_s; n <= -rd_s; ut <= lt + K2 - rd_s;
          idx <= lt + K2 - rd_s;
          if (rd_s >= 0 || lt + K2 - rd_s > TOP) state <= S_OUT;
          else state <= S_F1;
        end
        S_F1: state <= S_F1W;
        S_F1W: begin
          if (rd_s != v) state <= S_OUT;
          else if (lt >= K2) begin idx <= lt - K2; state <= S_F2; end
          else begin idx <= ut + K2; state <= S_F3; end
        end
        S_F2: state <= S_F2W;
        S_F2W: begin
          bv <= rd_s;
          below <= (rd_s >= 0) && (lt - K4 - rd_s >= 0);
          idx <= ut + K2;
          state <= S_F3;
        end
        S_F3: state <= (ut + K2 <= TOP) ? S_F3W : S_FW1;
        S_F3W: begin
          av <= rd_s;
          above <= (rd_s >= 0) && (ut + K4 + rd_s <= TOP);
          state <= S_FW1;
        end
        S_FW1: state <= S_FW2;
        S_FW2: state <= S_OUT;
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      // Free write-back targets, formed once merge flags are known.
      if (state == S_F3W || (state == S_F3 && !(ut + K2 <= TOP))) begin
        logic b, a;
        logic signed [VW-1:0] avx;
        b = below;
        avx = (state == S_F3W) ? rd_s : av;
        a = (state == S_F3W) ? ((rd_s >= 0) && (ut + K4 + rd_s <= TOP)) : 1'b0;
        if (b && a) begin
          w1a <= lt - K4 - bv; w2a <= ut + K4 + avx;
          w1v <= sat((VW+2)'(bv) + (VW+2)'(avx) + (VW+2)'(n) + (VW+2)'(8));
          w2v <= sat((VW+2)'(bv) + (VW+2)'(avx) + (VW+2)'(n) + (VW+2)'(8));
        end else if (b) begin
          w1a <= lt - K4 - bv; w2a <= ut;
          w1v <= sat((VW+2)'(bv) + (VW+2)'(n) + (VW+2)'(4));
          w2v <= sat((VW+2)'(bv) + (VW+2)'(n) + (VW+2)'(4));
        end else if (a) begin
          w1a <= ut + K4 + avx; w2a <= lt;
          w1v <= sat((VW+2)'(avx) + (VW+2)'(n) + (VW+2)'(4));
          w2v <= sat((VW+2)'(avx) + (VW+2)'(n) + (VW+2)'(4));
        end else begin
          w1a <= lt; w2a <= ut; w1v <= n; w2v <= n;
        end
      end
    end
  end

  // Checks.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("request taken while busy");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
    else $error("response dropped");
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_ALLOCATED |-> rsp.alloc_addr == 0)
    else $error("address on failure");
endmodule

// ----- tb/boundary_tag_heap_allocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_tb
// Drives allocate and free requests into the heap allocator with random
// gaps on the request side and random stalls on the response side. Typed
// directed rows are checked against fixed expectations, all others against a tag-level prediction of the heap.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator_tb;
  import bta_pkg::*;

  localparam int HW = HEAP_WORDS_DEFAULT;
  localparam int RANDOM_ITEMS = 950;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] addr;
  } rsp_t;

  typedef struct packed {
    logic        req_type;
    logic [13:0] num_bytes;
    logic [13:0] free_addr;
    logic        typed;
    logic [1:0]  exp_status;
    logic [13:0] exp_addr;
  } dir_row_t;

  logic clk;
  logic rst;

  bta_req_if req ();
  bta_rsp_if rsp ();

  boundary_tag_heap_allocator u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Predicted heap tags and the responses still owed by the block.
  int   heap_tags [HW];
  rsp_t pending_rsp [$];
  int   live_addrs [$];
  int   error_count;
  logic no_idle;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung block.
  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("%0t ERROR %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic int tag_rd(input int i);
    if (i < 0 || i >= HW) return 0;
    return heap_tags[i];
  endfunction

  function automatic void tag_wr(input int i, input int v);
    if (i < 0 || i >= HW) return;
    if (v > HW) v = HW;
    if (v < -HW) v = -HW;
    heap_tags[i] = v;
  endfunction

  function automatic void heap_reset();
    foreach (heap_tags[i]) heap_tags[i] = 0;
    heap_tags[0]      = HW - 4;
    heap_tags[HW - 2] = HW - 4;
  endfunction

  // First-fit walk from the top of the heap, cutting from the top of a block.
  function automatic rsp_t alloc_predict(input logic [13:0] bytes);
    rsp_t res;
    int   nw;
    int   idx;
    int   v;
    int   r;
    int   rem;
    res.status = ST_NO_SPACE;
    res.addr   = '0;
    nw  = (int'(bytes) + 3) >> 2;
    idx = HW - 2;
    if (nw == 0) return res;
    for (int steps = 0; steps < HW && idx >= 2; steps++) begin
      v = tag_rd(idx);
      if (v >= nw + 4) begin
        r   = idx - nw;
        rem = v - nw - 4;
        if (idx - v - 2 < 0) return res;
        tag_wr(idx, -nw);
        tag_wr(r - 2, -nw);
        tag_wr(r - 4, rem);
        tag_wr(r - 4 - rem - 2, rem);
        res.status = ST_ALLOCATED;
        res.addr   = 14'(r << 2);
        return res;
      end
      idx = idx - (v < 0 ? -v : v) - 4;
    end
    return res;
  endfunction

  // Release a block and merge it with free neighbors that lie inside the heap.
  function automatic void free_predict(input logic [13:0] addr);
    int a;
    int lt;
    int ut;
    int n;
    int v;
    int bv;
    int av;
    int blow;
    int aup;
    bit below;
    bit above;
    a     = int'(addr) >> 2;
    lt    = a - 2;
    below = 0;
    above = 0;
    if (lt < 0) return;
    v = tag_rd(lt);
    if (v >= 0) return;
    n  = -v;
    ut = a + n;
    if (ut > HW - 2) return;
    if (tag_rd(ut) != v) return;
    if (lt >= 2) begin
      bv   = tag_rd(lt - 2);
      blow = lt - 2 - bv - 2;
      if (bv >= 0 && blow >= 0) below = 1;
    end
    if (ut + 2 <= HW - 2) begin
      av  = tag_rd(ut + 2);
      aup = ut + 2 + av + 2;
      if (av >= 0 && aup <= HW - 2) above = 1;
    end
    if (below && above) begin
      tag_wr(blow, bv + av + n + 8);
      tag_wr(aup, bv + av + n + 8);
    end else if (below) begin
      tag_wr(blow, bv + n + 4);
      tag_wr(ut, bv + n + 4);
    end else if (above) begin
      tag_wr(aup, av + n + 4);
      tag_wr(lt, av + n + 4);
    end else begin
      tag_wr(lt, n);
      tag_wr(ut, n);
    end
  endfunction

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Present one request, wait for its transfer, then update the prediction.
  task automatic send_request(input logic rt, input logic [13:0] nb, input logic [13:0] fa,
                              input logic typed, input rsp_t typed_rsp);
    int   gap;
    rsp_t pred;
    gap = draw_wait();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.req_type  <= rt;
    req.num_bytes <= nb;
    req.free_addr <= fa;
    do @(posedge clk); while (!req.ready);
    if (rt == REQ_ALLOC) begin
      pred = alloc_predict(nb);
      if (pred.status == ST_ALLOCATED) live_addrs.push_back(int'(pred.addr));
    end else begin
      free_predict(fa);
      pred.status = ST_FREED;
      pred.addr   = '0;
    end
    pending_rsp.push_back(typed ? typed_rsp : pred);
  endtask

  // Response side: random stalls before each transfer.
  initial begin
    int stall;
    rsp.ready <= 1'b0;
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  // Compare each response transfer with the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response, status", int'(rsp.status), -1);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", int'(rsp.status), int'(want.status));
        if (rsp.alloc_addr !== want.addr)
          report_mismatch("alloc_addr", int'(rsp.alloc_addr), int'(want.addr));
      end
    end
  end

  // Directed rows. Typed expectations assume the rows run in order from the empty heap left by reset.
  dir_row_t dir_rows [] = '{
    '{REQ_ALLOC, 14'd0,     14'd0,     1'b1, ST_NO_SPACE,  14'd0},
    '{REQ_ALLOC, 14'd16368, 14'd0,     1'b1, ST_NO_SPACE,  14'd0},
    '{REQ_ALLOC, 14'd16352, 14'd0,     1'b1, ST_ALLOCATED, 14'd24},
    '{REQ_FREE,  14'd0,     14'd24,    1'b1, ST_FREED,     14'd0},
    '{REQ_ALLOC, 14'd1,     14'd0,     1'b1, ST_ALLOCATED, 14'd16372},
    '{REQ_FREE,  14'd0,     14'd16372, 1'b1, ST_FREED,     14'd0},
    '{REQ_ALLOC, 14'd16,    14'd0,     1'b1, ST_ALLOCATED, 14'd16360},
    '{REQ_ALLOC, 14'd3,     14'd0,     1'b1, ST_ALLOCATED, 14'd16340},
    '{REQ_ALLOC, 14'd4,     14'd0,     1'b1, ST_ALLOCATED, 14'd16320},
    '{REQ_FREE,  14'd0,     14'd16340, 1'b1, ST_FREED,     14'd0},
    '{REQ_ALLOC, 14'd5,     14'd0,     1'b0, ST_NO_SPACE,  14'd0},
    '{REQ_ALLOC, 14'd2,     14'd0,     1'b0, ST_NO_SPACE,  14'd0},
    '{REQ_FREE,  14'd0,     14'd16343, 1'b0, ST_FREED,     14'd0},
    '{REQ_FREE,  14'd0,     14'd0,     1'b1, ST_FREED,     14'd0},
    '{REQ_FREE,  14'd0,     14'd16383, 1'b0, ST_FREED,     14'd0},
    '{REQ_FREE,  14'd0,     14'd16320, 1'b0, ST_FREED,     14'd0},
    '{REQ_FREE,  14'd0,     14'd16320, 1'b0, ST_FREED,     14'd0},
    '{REQ_ALLOC, 14'd16368, 14'd0,     1'b0, ST_NO_SPACE,  14'd0},
    '{REQ_FREE,  14'd0,     14'd16360, 1'b0, ST_FREED,     14'd0},
    '{REQ_ALLOC, 14'd16337, 14'd0,     1'b0, ST_NO_SPACE,  14'd0},
    '{REQ_ALLOC, 14'd9992,  14'd0,     1'b0, ST_NO_SPACE,  14'd0},
    '{REQ_ALLOC, 14'd2496,  14'd0,     1'b0, ST_NO_SPACE,  14'd0}
  };

  // Main stimulus.
  initial begin
    rsp_t      typed_rsp;
    logic      rt;
    logic [13:0] nb;
    logic [13:0] fa;
    int        pick;
    int        k;
    bit        draining;
    int        wait_cycles;
    error_count   = 0;
    no_idle       = 1'b0;
    draining      = 0;
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.req_type  <= REQ_ALLOC;
    req.num_bytes <= '0;
    req.free_addr <= '0;
    heap_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    foreach (dir_rows[i]) begin
      typed_rsp.status = dir_rows[i].exp_status;
      typed_rsp.addr   = dir_rows[i].exp_addr;
      send_request(dir_rows[i].req_type, dir_rows[i].num_bytes, dir_rows[i].free_addr,
                   dir_rows[i].typed, typed_rsp);
    end

    // Random part: mostly well-formed alloc/free traffic with some noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n % 211 == 0) draining = 1;
      if (live_addrs.size() == 0) draining = 0;
      pick = $urandom_range(0, 99);
      rt   = REQ_ALLOC;
      nb   = '0;
      fa   = '0;
      if (draining || (live_addrs.size() > 40 && pick < 60) ||
          (live_addrs.size() > 0 && pick < 40)) begin
        // Release a block that is known to be allocated.
        k  = $urandom_range(0, live_addrs.size() - 1);
        rt = REQ_FREE;
        fa = 14'(live_addrs[k]);
        live_addrs.delete(k);
      end else if (pick < 48) begin
        // Noise: arbitrary or misaligned free address.
        rt = REQ_FREE;
        fa = 14'($urandom_range(0, 16383));
      end else if (pick < 52) begin
        nb = 14'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(8192, 16368));
      end else if (pick < 60) begin
        nb = 14'($urandom_range(0, 2047));
      end else begin
        nb = 14'($urandom_range(1, 64));
      end
      typed_rsp = '0;
      send_request(rt, nb, fa, 1'b0, typed_rsp);
    end
    req.valid <= 1'b0;

    // Drain the outstanding responses, then let the block settle.
    wait_cycles = 0;
    while (pending_rsp.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bta_pkg.sv
rtl/core/bta_if.sv
rtl/core/bta_tag_ram.sv
rtl/core/boundary_tag_heap_allocator.sv
tb/boundary_tag_heap_allocator_tb.sv
